// ===== hdl/dcla_pkg.sv =====
// ----------------------------------------------------------------------------
// dcla_pkg
// Types, constants and helper functions for the decayed causal linear
// attention block.
// ----------------------------------------------------------------------------
package dcla_pkg;

	localparam int MAX_DIM_DEF   = 16;
	localparam int EXP_DEPTH_DEF = 256;

	// row index and dimension fields sized for the largest allowed MAX_DIM (64)
	localparam int ROW_W = 6;
	localparam int DIM_W = 7;

	localparam int MAT_W = 48;
	localparam int ACC_W = 58;

	localparam longint unsigned LN2_Q30   = 64'd744261118;
	localparam logic [16:0]     LOG2E_Q16 = 17'd94548;
	localparam logic [16:0]     ALPHA_ONE = 17'h10000;

	// ceil(2^34 / k) for k = 1..16: exact floor division of any dividend below 2^30
	localparam longint unsigned RECIP_ONE = 64'd1 << 34;
	localparam longint unsigned SERIES_RECIP [16] = '{
		(RECIP_ONE + 64'd0) / 64'd1,    (RECIP_ONE + 64'd1) / 64'd2,
		(RECIP_ONE + 64'd2) / 64'd3,    (RECIP_ONE + 64'd3) / 64'd4,
		(RECIP_ONE + 64'd4) / 64'd5,    (RECIP_ONE + 64'd5) / 64'd6,
		(RECIP_ONE + 64'd6) / 64'd7,    (RECIP_ONE + 64'd7) / 64'd8,
		(RECIP_ONE + 64'd8) / 64'd9,    (RECIP_ONE + 64'd9) / 64'd10,
		(RECIP_ONE + 64'd10) / 64'd11,  (RECIP_ONE + 64'd11) / 64'd12,
		(RECIP_ONE + 64'd12) / 64'd13,  (RECIP_ONE + 64'd13) / 64'd14,
		(RECIP_ONE + 64'd14) / 64'd15,  (RECIP_ONE + 64'd15) / 64'd16
	};

	localparam logic [1:0] REG_ACTIVE_DIM = 2'd0;
	localparam logic [1:0] REG_DECAY_EN   = 2'd1;

	typedef struct packed {
		logic               head_start;
		logic signed [15:0] query_elem;
		logic signed [15:0] key_elem;
		logic signed [15:0] value_elem;
		logic signed [23:0] log_decay;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_elem;
		logic               last_out;
	} out_item_t;

	typedef struct packed {
		logic [1:0] index;
		logic [7:0] wdata;
	} cfg_item_t;

	// one matrix row travelling down the cell chain
	typedef struct packed {
		logic               valid;
		logic               use_row;
		logic [ROW_W-1:0]   row;
		logic signed [15:0] key;
		logic signed [15:0] query;
	} row_t;

	// broadcast controls from the sequencer to every cell
	typedef struct packed {
		logic               clear_mat;
		logic               clear_acc;
		logic [16:0]        alpha;
		logic [DIM_W-1:0]   dim;
		logic               val_we;
		logic [ROW_W-1:0]   val_idx;
		logic signed [15:0] val_data;
	} cell_ctl_t;

	// exp(-x) in Q2.30 from a 16-term series, x in Q30 (callers scale by ln2 to get 2^-x)
	function automatic logic [31:0] exp_series(longint unsigned x);
		longint unsigned term;
		longint unsigned prod;
		longint          sum;
		term = 64'd1 << 30;
		sum  = 64'sd1 << 30;
		for (int k = 1; k <= 16; k++) begin
			prod = (term * x) >> 30;
			term = (prod * SERIES_RECIP[k-1]) >> 34;
			if (k[0]) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		return sum[31:0];
	endfunction

	function automatic logic signed [MAT_W-1:0] sat_mat(logic signed [50:0] s);
		if (s[50:47] != {4{s[47]}}) begin
			return s[50] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
		end
		return s[47:0];
	endfunction

	function automatic logic signed [31:0] sat_out(logic signed [ACC_W-1:0] a);
		if (a[ACC_W-1:31] != {(ACC_W-31){a[31]}}) begin
			return a[ACC_W-1] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
		end
		return a[31:0];
	endfunction

endpackage

// ===== hdl/dcla_chan_if.sv =====
// ----------------------------------------------------------------------------
// dcla_chan_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface dcla_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/dcla_decay.sv =====
// ----------------------------------------------------------------------------
// dcla_decay
// Decay factor pipeline: exp of the log-decay difference via a 2^-x table,
// Q1.16 result, four register stages.
// ----------------------------------------------------------------------------
module dcla_decay #(
	parameter int EXP_TABLE_DEPTH = dcla_pkg::EXP_DEPTH_DEF
) (
	input  logic               clk,
	input  logic signed [23:0] cur_ld,
	input  logic signed [23:0] prev_ld,
	input  logic               apply,
	output logic [16:0]        alpha
);
	import dcla_pkg::*;

	localparam int IW = $clog2(EXP_TABLE_DEPTH);
	localparam logic [IW:0] DEPTH_V = (IW+1)'(EXP_TABLE_DEPTH);

	logic [31:0] exp_rom [EXP_TABLE_DEPTH];

	for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_rom
		localparam longint unsigned X = (LN2_Q30 * g) / EXP_TABLE_DEPTH;
		assign exp_rom[g] = exp_series(X);
	end

	logic signed [24:0] diff_c;
	logic [23:0]        m_s1;
	logic               keep_s1, keep_s2, keep_s3;
	logic [40:0]        y_s2;
	logic [8:0]         n_s3;
	logic [IW-1:0]      idx_s3;
	logic [32+IW:0]     idx_prod_c;
	logic [4:0]         sh_c;
	logic [32:0]        rnd_c;

	assign diff_c     = 25'(cur_ld) - 25'(prev_ld);
	assign idx_prod_c = (33+IW)'(y_s2[31:0]) * (33+IW)'(DEPTH_V);
	assign sh_c       = 5'd14 + n_s3[4:0];
	assign rnd_c      = ({1'b0, exp_rom[idx_s3]} + (33'd1 << (sh_c - 5'd1))) >> sh_c;

	always_ff @(posedge clk) begin
		m_s1    <= 24'(-diff_c);
		keep_s1 <= !apply || !diff_c[24];
		y_s2    <= 41'(m_s1) * 41'(LOG2E_Q16);
		keep_s2 <= keep_s1;
		n_s3    <= y_s2[40:32];
		idx_s3  <= idx_prod_c[32 +: IW];
		keep_s3 <= keep_s2;
		priority if (keep_s3) begin
			alpha <= ALPHA_ONE;
		end else if (n_s3 >= 9'd18) begin
			alpha <= '0;
		end else begin
			alpha <= rnd_c[16:0];
		end
	end

endmodule

// ===== hdl/dcla_cell.sv =====
// ----------------------------------------------------------------------------
// dcla_cell
// One matrix column: decays, updates and reads its entries as rows pass by,
// accumulates query times column, hands each row on to the next cell.
// ----------------------------------------------------------------------------
module dcla_cell #(
	parameter int MAX_DIM = dcla_pkg::MAX_DIM_DEF,
	parameter int COL     = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dcla_pkg::cell_ctl_t  ctl,
	input  dcla_pkg::row_t       row_in,
	output dcla_pkg::row_t       row_out,
	output logic signed [31:0]   result
);
	import dcla_pkg::*;

	localparam int AW = $clog2(MAX_DIM);

	logic signed [MAT_W-1:0] mem [MAX_DIM];
	logic [MAX_DIM-1:0]      vbit_q;
	logic signed [15:0]      val_q;

	row_t                    row_s1, row_s2, row_s3;
	logic signed [MAT_W-1:0] rd_s1;
	logic                    rv_s1;
	logic [64:0]             sc_s2;
	logic                    neg_s2;
	logic signed [31:0]      kv_s2;
	logic signed [MAT_W-1:0] new_s3;
	logic signed [63:0]      qp_s4;
	logic                    use_s4;
	logic signed [ACC_W-1:0] acc_q;

	logic signed [MAT_W-1:0] entry_c;
	logic [MAT_W-1:0]        mag_c;
	logic                    add_en_c;
	logic [48:0]             scm_c;
	logic signed [49:0]      scs_c;
	logic signed [50:0]      sum_c;
	logic [63:0]             qmag_c;
	logic [51:0]             qrm_c;
	logic signed [52:0]      qrnd_c;

	always_comb begin
		entry_c  = rv_s1 ? rd_s1 : '0;
		mag_c    = entry_c[MAT_W-1] ? MAT_W'(-entry_c) : MAT_W'(entry_c);
		add_en_c = row_s1.use_row && (DIM_W'(COL) < ctl.dim);
		scm_c    = 49'((sc_s2 + 65'h8000) >> 16);
		scs_c    = neg_s2 ? -$signed({1'b0, scm_c}) : $signed({1'b0, scm_c});
		sum_c    = 51'(scs_c) + 51'(kv_s2);
		qmag_c   = qp_s4[63] ? 64'(-qp_s4) : 64'(qp_s4);
		qrm_c    = 52'((qmag_c + 64'd2048) >> 12);
		qrnd_c   = qp_s4[63] ? -$signed({1'b0, qrm_c}) : $signed({1'b0, qrm_c});
	end

	assign row_out = row_s1;
	assign result  = sat_out(acc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_s1 <= '0;
			row_s2 <= '0;
			row_s3 <= '0;
			use_s4 <= 1'b0;
			vbit_q <= '0;
			acc_q  <= '0;
		end else begin
			row_s1 <= row_in;
			row_s2 <= row_s1;
			row_s3 <= row_s2;
			use_s4 <= row_s3.valid && row_s3.use_row;
			if (ctl.clear_mat) begin
				vbit_q <= '0;
			end else if (row_s3.valid) begin
				vbit_q[row_s3.row[AW-1:0]] <= 1'b1;
			end
			if (ctl.clear_acc) begin
				acc_q <= '0;
			end else if (use_s4) begin
				acc_q <= acc_q + ACC_W'(qrnd_c);
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_s1  <= mem[row_in.row[AW-1:0]];
		rv_s1  <= vbit_q[row_in.row[AW-1:0]];
		sc_s2  <= 65'(mag_c) * 65'(ctl.alpha);
		neg_s2 <= entry_c[MAT_W-1];
		kv_s2  <= add_en_c ? $signed(row_s1.key) * val_q : 32'sd0;
		new_s3 <= sat_mat(sum_c);
		qp_s4  <= $signed(row_s3.query) * new_s3;
		if (row_s3.valid) begin
			mem[row_s3.row[AW-1:0]] <= new_s3;
		end
		if (ctl.val_we && ctl.val_idx == ROW_W'(COL)) begin
			val_q <= ctl.val_data;
		end
	end

endmodule

// ===== hdl/decayed_causal_linear_attention_top.sv =====
// Token of D items: items are taken one per cycle; the last item starts a
// matrix pass (decay factor, row issue, cell chain drain), then D results
// leave one per cycle while res is ready. No new token is taken until the
// last result of the current token has left.
// Reset clears control state and the per-entry valid bits of the matrix,
// so the matrix reads as zero at once; no clearing pass.
// ----------------------------------------------------------------------------
// decayed_causal_linear_attention_top
// Streamed causal linear attention with per-token decay: sequencer, element
// buffers, decay factor unit and a chain of column cells.
// ----------------------------------------------------------------------------
module decayed_causal_linear_attention_top #(
	parameter int MAX_DIM         = dcla_pkg::MAX_DIM_DEF,
	parameter int EXP_TABLE_DEPTH = dcla_pkg::EXP_DEPTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	dcla_chan_if.sink   tok,
	dcla_chan_if.sink   cfg,
	dcla_chan_if.source res
);
	import dcla_pkg::*;

	localparam int AW = $clog2(MAX_DIM);
	localparam int CW = $clog2(MAX_DIM + 8);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DECAY = 3'd1;
	localparam logic [2:0] ST_PASS  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0]         state_q;
	logic [CW-1:0]      cnt_q;
	logic [4:0]         active_dim_q;
	logic               decay_en_q;
	logic [AW-1:0]      elem_q;
	logic               first_q;
	logic signed [23:0] prev_ld_q, cur_ld_q;
	logic               apply_q;
	logic [DIM_W-1:0]   d_q;
	logic [16:0]        alpha_q;
	logic [16:0]        alpha_c;
	logic signed [15:0] key_buf [MAX_DIM];
	logic signed [15:0] qry_buf [MAX_DIM];

	logic               tok_acc, cfg_acc, res_acc;
	logic [DIM_W-1:0]   d_cfg;
	logic [AW-1:0]      e_c;
	logic               tok_last;
	cell_ctl_t          ctl;
	row_t               chain [MAX_DIM];
	logic signed [31:0] results [MAX_DIM];

	assign tok.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign tok_acc   = tok.valid && tok.ready;
	assign cfg_acc   = cfg.valid && cfg.ready;
	assign res_acc   = res.valid && res.ready;

	always_comb begin
		if (active_dim_q == '0) begin
			d_cfg = DIM_W'(1);
		end else if (DIM_W'(active_dim_q) > DIM_W'(MAX_DIM)) begin
			d_cfg = DIM_W'(MAX_DIM);
		end else begin
			d_cfg = DIM_W'(active_dim_q);
		end
		e_c      = tok.data.head_start ? '0 : elem_q;
		tok_last = (DIM_W'(e_c) + DIM_W'(1)) >= d_cfg;

		ctl.clear_mat = tok_acc && tok.data.head_start;
		ctl.clear_acc = (state_q == ST_DECAY);
		ctl.alpha     = alpha_q;
		ctl.dim       = d_q;
		ctl.val_we    = tok_acc;
		ctl.val_idx   = ROW_W'(e_c);
		ctl.val_data  = tok.data.value_elem;

		chain[0].valid   = (state_q == ST_PASS);
		chain[0].use_row = DIM_W'(cnt_q) < d_q;
		chain[0].row     = ROW_W'(cnt_q);
		chain[0].key     = key_buf[cnt_q[AW-1:0]];
		chain[0].query   = qry_buf[cnt_q[AW-1:0]];

		res.valid         = (state_q == ST_EMIT);
		res.data.out_elem = results[cnt_q[AW-1:0]];
		res.data.last_out = (DIM_W'(cnt_q) + DIM_W'(1)) == d_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			active_dim_q <= 5'd16;
			decay_en_q   <= 1'b0;
			elem_q       <= '0;
			first_q      <= 1'b1;
			prev_ld_q    <= '0;
			cur_ld_q     <= '0;
			apply_q      <= 1'b0;
			d_q          <= '0;
		end else begin
			if (cfg_acc) begin
				unique case (cfg.data.index)
					REG_ACTIVE_DIM: active_dim_q <= cfg.data.wdata[4:0];
					REG_DECAY_EN:   decay_en_q   <= cfg.data.wdata[0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (tok_acc) begin
						if (e_c == '0) begin
							cur_ld_q <= tok.data.log_decay;
						end
						if (tok_last) begin
							elem_q  <= '0;
							first_q <= 1'b0;
							apply_q <= decay_en_q && !(tok.data.head_start || first_q);
							d_q     <= d_cfg;
							cnt_q   <= '0;
							state_q <= ST_DECAY;
						end else begin
							elem_q  <= e_c + AW'(1);
							first_q <= tok.data.head_start || first_q;
						end
					end
				end
				ST_DECAY: begin
					if (cnt_q == CW'(4)) begin
						prev_ld_q <= cur_ld_q;
						cnt_q     <= '0;
						state_q   <= ST_PASS;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_PASS: begin
					if (cnt_q == CW'(MAX_DIM - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_DRAIN: begin
					if (cnt_q == CW'(MAX_DIM + 6)) begin
						cnt_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_EMIT: begin
					if (res_acc) begin
						if (res.data.last_out) begin
							cnt_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tok_acc) begin
			key_buf[e_c] <= tok.data.key_elem;
			qry_buf[e_c] <= tok.data.query_elem;
		end
		// hold the factor for the whole pass
		if (state_q == ST_DECAY && cnt_q == CW'(4)) begin
			alpha_q <= alpha_c;
		end
	end

	dcla_decay #(
		.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
	) u_decay (
		.clk     (clk),
		.cur_ld  (cur_ld_q),
		.prev_ld (prev_ld_q),
		.apply   (apply_q),
		.alpha   (alpha_c)
	);

	for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
		if (g < MAX_DIM - 1) begin : g_mid
			dcla_cell #(
				.MAX_DIM(MAX_DIM),
				.COL    (g)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.row_in  (chain[g]),
				.row_out (chain[g+1]),
				.result  (results[g])
			);
		end else begin : g_end
			dcla_cell #(
				.MAX_DIM(MAX_DIM),
				.COL    (g)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.row_in  (chain[g]),
				.row_out (),
				.result  (results[g])
			);
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(tok.ready && res.valid))
		else $error("input taken while results pending");

	a_last_starts_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_acc && tok_last) |=> (state_q == ST_DECAY))
		else $error("token end did not start the matrix pass");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (DIM_W'(cnt_q) < d_q))
		else $error("result index beyond token dimension");

	a_last_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_acc && res.data.last_out) |=> (state_q == ST_IDLE))
		else $error("block did not return to idle after final result");

endmodule
